FILE: rtl/core/bhq_pkg.sv
// Shared types and constants for the binary min-heap queue.
// No dependencies; imported by every module of the block but bhq_ram.
package bhq_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int ID_W         = 8;
    localparam int KEY_W        = 16;
    localparam int ENTRY_W      = ID_W + KEY_W;

    typedef enum logic {
        OP_PUSH    = 1'b0,
        OP_EXTRACT = 1'b1
    } op_t;

    // id in the upper bits, key in the lower bits
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic is_empty;
        logic is_full;
        logic refused;
    } flags_t;

endpackage

FILE: rtl/core/bhq_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module bhq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/bhq_ctrl.sv
// Heap sequencer: sift-up / sift-down over one RAM port pair, one level per step.
// Depends on bhq_pkg and bhq_ram.
module bhq_ctrl #(
    parameter int  CAPACITY = bhq_pkg::DEF_CAPACITY,
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bhq_pkg::op_t     in_op,
    input  bhq_pkg::entry_t  in_entry,
    output logic             res_valid,
    input  logic             res_ready,
    output bhq_pkg::entry_t  res_entry,
    output logic [CW-1:0]    res_count,
    output bhq_pkg::flags_t  res_flags
);

    import bhq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_FIN,
        S_DN_LOAD,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   s_reg, s_next;
    entry_t          x_reg, x_next;
    entry_t          c_reg, c_next;
    entry_t          root_reg, root_next;
    entry_t          ext_reg, ext_next;
    logic            push_reg, push_next;
    logic            refused_reg, refused_next;

    logic            ram_we;
    logic [CW-1:0]   wslot;
    entry_t          wdata;
    logic [CW:0]     rslot;
    logic [CW-1:0]   wdec;
    logic [CW:0]     rdec;
    logic [ENTRY_W-1:0] rdata_raw;
    entry_t          rd;

    logic [CW:0]     n_w;
    logic [CW:0]     l_w;
    logic [CW:0]     r_w;
    logic [CW-1:0]   parent;
    entry_t          cand;
    logic [CW:0]     cidx_w;
    logic [CW:0]     nl_w;
    logic            is_full;

    assign wdec = wslot - CW'(1);
    assign rdec = rslot - (CW+1)'(1);
    assign rd   = entry_t'(rdata_raw);

    bhq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wdec[AW-1:0]),
        .wdata (wdata),
        .raddr (rdec[AW-1:0]),
        .rdata (rdata_raw)
    );

    assign n_w     = {1'b0, count_reg};
    assign l_w     = {s_reg, 1'b0};
    assign r_w     = l_w + (CW+1)'(1);
    assign parent  = s_reg >> 1;
    assign is_full = (count_reg == CW'(CAPACITY));

    // right child wins a key tie
    always_comb
    begin
        if (state_reg == S_DN_R && !(c_reg.key < rd.key))
        begin
            cand   = rd;
            cidx_w = r_w;
        end
        else
        begin
            cand   = c_reg;
            cidx_w = l_w;
        end
    end

    assign nl_w = {cidx_w[CW-1:0], 1'b0};

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        s_next       = s_reg;
        x_next       = x_reg;
        c_next       = c_reg;
        ext_next     = ext_reg;
        push_next    = push_reg;
        refused_next = refused_reg;
        ram_we       = 1'b0;
        wslot        = s_reg;
        wdata        = x_reg;
        rslot        = (CW+1)'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    refused_next = 1'b0;
                    push_next    = (in_op == OP_PUSH);
                    if (in_op == OP_PUSH)
                    begin
                        if (is_full)
                        begin
                            refused_next = 1'b1;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            s_next     = count_reg + CW'(1);
                            x_next     = in_entry;
                            if (count_reg == '0)
                            begin
                                ram_we     = 1'b1;
                                wslot      = CW'(1);
                                wdata      = in_entry;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rslot      = {1'b0, (count_reg + CW'(1)) >> 1};
                                state_next = S_UP_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            refused_next = 1'b1;
                            ext_next     = '0;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            ext_next   = root_reg;
                            count_next = count_reg - CW'(1);
                            if (count_reg == CW'(1))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rslot      = n_w;
                                state_next = S_DN_LOAD;
                            end
                        end
                    end
                end
            end

            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (rd.key > x_reg.key)
                begin
                    wdata  = rd;
                    s_next = parent;
                    if (parent == CW'(1))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        rslot = {1'b0, parent >> 1};
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FIN:
            begin
                ram_we     = 1'b1;
                state_next = S_DONE;
            end

            S_DN_LOAD:
            begin
                x_next = rd;
                s_next = CW'(1);
                if ((CW+1)'(2) <= n_w)
                begin
                    rslot      = (CW+1)'(2);
                    state_next = S_DN_L;
                end
                else
                begin
                    ram_we     = 1'b1;
                    wslot      = CW'(1);
                    wdata      = rd;
                    state_next = S_DONE;
                end
            end

            S_DN_L:
            begin
                c_next = rd;
                if (r_w <= n_w)
                begin
                    rslot      = r_w;
                    state_next = S_DN_R;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end

            S_DN_R,
            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (cand.key < x_reg.key)
                begin
                    wdata  = cand;
                    s_next = cidx_w[CW-1:0];
                    if (nl_w <= n_w)
                    begin
                        rslot      = nl_w;
                        state_next = S_DN_L;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // root copy follows every write to slot one
    always_comb
    begin
        root_next = root_reg;
        if (ram_we && wslot == CW'(1))
        begin
            root_next = wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            s_reg       <= '0;
            x_reg       <= '0;
            c_reg       <= '0;
            root_reg    <= '0;
            ext_reg     <= '0;
            push_reg    <= 1'b0;
            refused_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            s_reg       <= s_next;
            x_reg       <= x_next;
            c_reg       <= c_next;
            root_reg    <= root_next;
            ext_reg     <= ext_next;
            push_reg    <= push_next;
            refused_reg <= refused_next;
        end
    end

    assign in_ready           = (state_reg == S_IDLE);
    assign res_valid          = (state_reg == S_DONE);
    assign res_entry          = push_reg ? root_reg : ext_reg;
    assign res_count          = count_reg;
    assign res_flags.is_empty = (count_reg == '0);
    assign res_flags.is_full  = is_full;
    assign res_flags.refused  = refused_reg;

endmodule

FILE: rtl/core/binary_min_heap_queue_top.sv
// Binary min-heap priority queue, top level: stream ports and output register.
// Depends on bhq_pkg, bhq_ctrl (and bhq_ram below it).
//
//  channel  | dir | tdata                                      | tuser
//  ---------+-----+--------------------------------------------+------
//  s_axis   | in  | item_id, item_key                          | op
//  m_axis   | out | min_id, min_key, count, is_empty, is_full, | -
//           |     | refused                                    |
//
// One word at a time. A push climbs from the new leaf toward the root; an extract loads
// the last entry, then descends from the root, reading the left and, where present, right
// child at each level. The single RAM read port serializes these reads. The result sits
// in an output register, so the next word is taken while it waits. s_tready drops from
// acceptance until the result is handed to the register.
// Reset empties the heap; RAM contents are not cleared.
module binary_min_heap_queue_top #(
    parameter int  CAPACITY = bhq_pkg::DEF_CAPACITY,
    localparam int CW       = $clog2(CAPACITY + 1),
    localparam int OUT_BITS = bhq_pkg::ENTRY_W + CW + 3,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bhq_pkg::ENTRY_W-1:0]   s_tdata,   // item_id, item_key
    input  logic                          s_tuser,   // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata    // min_id, min_key, count,
                                                     // is_empty, is_full, refused, pad
);

    import bhq_pkg::*;

    logic            res_valid;
    logic            res_ready;
    entry_t          res_entry;
    logic [CW-1:0]   res_count;
    flags_t          res_flags;
    entry_t          in_entry;

    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    assign in_entry.id  = s_tdata[ID_W-1:0];
    assign in_entry.key = s_tdata[ENTRY_W-1:ID_W];

    bhq_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tuser)),
        .in_entry  (in_entry),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_entry (res_entry),
        .res_count (res_count),
        .res_flags (res_flags)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready)
        begin
            m_valid_next = res_valid;
            if (res_valid)
            begin
                m_data_next = OUT_W'({res_flags.refused, res_flags.is_full,
                                      res_flags.is_empty, res_count,
                                      res_entry.key, res_entry.id});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: rtl/core/bhq_chk.sv
// Port-level checker for the heap queue, bound to the top level.
// Depends on bhq_pkg and binary_min_heap_queue_top.
module bhq_chk #(
    parameter int  CAPACITY = bhq_pkg::DEF_CAPACITY,
    localparam int CW       = $clog2(CAPACITY + 1),
    localparam int OUT_BITS = bhq_pkg::ENTRY_W + CW + 3,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [bhq_pkg::ENTRY_W-1:0] s_tdata,
    input logic                        s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [OUT_W-1:0]            m_tdata
);

    import bhq_pkg::*;

    localparam int CNT_LO = ENTRY_W;
    localparam int EMP_B  = ENTRY_W + CW;
    localparam int FUL_B  = ENTRY_W + CW + 1;

    logic [CW-1:0] cnt;
    assign cnt = m_tdata[EMP_B-1:CNT_LO];

    // a word is never taken back to back: the controller leaves idle on every accepted word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted word");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[EMP_B] == (cnt == '0)))
        else $error("is_empty disagrees with count");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[FUL_B] == (cnt == CW'(CAPACITY))))
        else $error("is_full disagrees with count");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

endmodule

bind binary_min_heap_queue_top bhq_chk #(.CAPACITY(CAPACITY)) u_bhq_chk (.*);

FILE: tb/sv/binary_min_heap_queue_top_tb.sv
// Testbench for binary_min_heap_queue_top: directed and random push/extract words,
// checked against an in-bench min-heap predictor. Depends on bhq_pkg and the RTL.
module binary_min_heap_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bhq_pkg::*;

    localparam int CAP         = 64;
    localparam int CNT_W       = 7;
    localparam int OUT_W       = 40;
    localparam int RAND_WORDS  = 690;
    localparam int DRAIN_AT    = 350;
    localparam int TAIL_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        op_t        op;
        logic [7:0] id;
        logic [15:0] key;
        bit         drain;
    } heap_word_t;

    typedef struct packed {
        logic [7:0]       id;
        logic [15:0]      key;
        logic [CNT_W-1:0] count;
        logic             is_empty;
        logic             is_full;
        logic             refused;
    } heap_result_t;

    logic             clk;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [23:0]      s_tdata  = '0;
    logic             s_tuser  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    heap_word_t   words_to_send[$];
    heap_result_t results_due[$];
    logic [7:0]   heap_ids[1:CAP];
    logic [15:0]  heap_keys[1:CAP];
    int           heap_n;
    int           words_total;
    int           words_sent;
    int           results_seen;
    int           errors;
    int           n_push;
    int           n_extract;
    int           n_refused;
    int           n_full;
    int           cycles;

    binary_min_heap_queue_top #(.CAPACITY(CAP)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // item_id, item_key
        .s_tuser  (s_tuser),   // op
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // min_id, min_key, count, is_empty, is_full, refused, pad
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic heap_result_t heap_apply(input op_t op, input logic [7:0] id,
                                                input logic [15:0] key);
        heap_result_t r;
        int           s;
        int           l;
        int           c;
        logic [7:0]   tid;
        logic [15:0]  tkey;
        bit           moving;
        r = '0;
        if (op == OP_PUSH)
        begin
            if (heap_n >= CAP)
                r.refused = 1'b1;
            else
            begin
                heap_n++;
                heap_ids[heap_n]  = id;
                heap_keys[heap_n] = key;
                s = heap_n;
                while (s > 1 && heap_keys[s / 2] > heap_keys[s])
                begin
                    tid  = heap_ids[s / 2];
                    tkey = heap_keys[s / 2];
                    heap_ids[s / 2]  = heap_ids[s];
                    heap_keys[s / 2] = heap_keys[s];
                    heap_ids[s]  = tid;
                    heap_keys[s] = tkey;
                    s = s / 2;
                end
            end
            if (heap_n > 0)
            begin
                r.id  = heap_ids[1];
                r.key = heap_keys[1];
            end
        end
        else
        begin
            if (heap_n == 0)
                r.refused = 1'b1;
            else
            begin
                r.id  = heap_ids[1];
                r.key = heap_keys[1];
                heap_ids[1]  = heap_ids[heap_n];
                heap_keys[1] = heap_keys[heap_n];
                heap_n--;
                s = 1;
                moving = 1'b1;
                while (moving && 2 * s <= heap_n)
                begin
                    l = 2 * s;
                    // key tie between children goes right
                    if (l + 1 <= heap_n)
                        c = (heap_keys[l] < heap_keys[l + 1]) ? l : l + 1;
                    else
                        c = l;
                    if (heap_keys[c] < heap_keys[s])
                    begin
                        tid  = heap_ids[c];
                        tkey = heap_keys[c];
                        heap_ids[c]  = heap_ids[s];
                        heap_keys[c] = heap_keys[s];
                        heap_ids[s]  = tid;
                        heap_keys[s] = tkey;
                        s = c;
                    end
                    else
                        moving = 1'b0;
                end
            end
        end
        r.count    = CNT_W'(heap_n);
        r.is_empty = (heap_n == 0);
        r.is_full  = (heap_n == CAP);
        return r;
    endfunction

    task automatic queue_word(input op_t op, input int id, input int key, input bit drain);
        heap_word_t w;
        w.op    = op;
        w.id    = id[7:0];
        w.key   = key[15:0];
        w.drain = drain;
        words_to_send.push_back(w);
    endtask

    function automatic int pick_key();
        int k;
        k = $urandom_range(0, 5);
        if (k < 2)
            return $urandom_range(0, 7);
        else if (k == 2)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        else
            return $urandom_range(0, 65535);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            bit         gap;
            heap_word_t w;
            if (s_tvalid && s_tready)
            begin
                results_due.push_back(heap_apply(op_t'(s_tuser), s_tdata[7:0], s_tdata[23:8]));
                if (op_t'(s_tuser) == OP_PUSH)
                    n_push++;
                else
                    n_extract++;
                words_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                gap = !(words_sent >= 400 && words_sent < 520) && ($urandom_range(0, 99) < 19);
                if (words_to_send.size() > 0 && !gap &&
                    !(words_to_send[0].drain && results_due.size() != 0))
                begin
                    w = words_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {w.key, w.id};
                    s_tuser  <= w.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    task automatic report_field(input string name, input int expv, input int gotv);
        if (expv != gotv)
        begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, expv, gotv);
            errors++;
        end
    endtask

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            heap_result_t exp_r;
            heap_result_t got;
            if (m_tvalid && m_tready)
            begin
                got.id       = m_tdata[7:0];
                got.key      = m_tdata[23:8];
                got.count    = m_tdata[30:24];
                got.is_empty = m_tdata[31];
                got.is_full  = m_tdata[32];
                got.refused  = m_tdata[33];
                results_seen++;
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    exp_r = results_due.pop_front();
                    report_field("min_id", exp_r.id, got.id);
                    report_field("min_key", exp_r.key, got.key);
                    report_field("count", exp_r.count, got.count);
                    report_field("is_empty", exp_r.is_empty, got.is_empty);
                    report_field("is_full", exp_r.is_full, got.is_full);
                    report_field("refused", exp_r.refused, got.refused);
                    if (exp_r.refused)
                        n_refused++;
                    if (exp_r.is_full)
                        n_full++;
                end
            end
            m_tready <= (results_seen >= 400 && results_seen < 520) ||
                        ($urandom_range(0, 99) >= 19);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, results_due.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int gen_n;
        int push_pct;
        int i;
        bit pushing;

        // directed: empty extract, field extremes, root ties, single-entry extract
        queue_word(OP_EXTRACT, 0, 0, 1'b0);
        queue_word(OP_PUSH, 255, 16'hFFFF, 1'b0);
        queue_word(OP_PUSH, 0, 16'h0000, 1'b0);
        queue_word(OP_PUSH, 170, 16'h0000, 1'b0);
        queue_word(OP_PUSH, 85, 16'h1234, 1'b0);
        queue_word(OP_PUSH, 15, 16'h8000, 1'b0);
        for (i = 0; i < 5; i++)
            queue_word(OP_EXTRACT, 0, 0, 1'b0);
        queue_word(OP_EXTRACT, 255, 16'hFFFF, 1'b0);
        queue_word(OP_PUSH, 1, 5, 1'b0);
        queue_word(OP_PUSH, 2, 5, 1'b0);
        queue_word(OP_PUSH, 3, 5, 1'b0);
        queue_word(OP_PUSH, 4, 9, 1'b0);
        for (i = 0; i < 4; i++)
            queue_word(OP_EXTRACT, 0, 0, 1'b0);

        // random: alternate fill and drain runs so the heap hits full and empty
        gen_n    = 0;
        push_pct = 80;
        for (i = 0; i < RAND_WORDS; i++)
        begin
            if (gen_n == CAP)
                push_pct = ($urandom_range(0, 3) == 0) ? 50 : 20;
            else if (gen_n == 0)
                push_pct = ($urandom_range(0, 3) == 0) ? 50 : 80;
            pushing = ($urandom_range(0, 99) < push_pct);
            if (pushing)
            begin
                queue_word(OP_PUSH, $urandom_range(0, 255), pick_key(), i == DRAIN_AT);
                if (gen_n < CAP)
                    gen_n++;
            end
            else
            begin
                queue_word(OP_EXTRACT, $urandom_range(0, 255), $urandom_range(0, 65535),
                           i == DRAIN_AT);
                if (gen_n > 0)
                    gen_n--;
            end
        end
        words_total = words_to_send.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (words_sent < words_total || results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d words (%0d pushes, %0d extracts), checked %0d results",
                 words_sent, n_push, n_extract, results_seen);
        $display("%0d refused operations, %0d results with the heap full", n_refused, n_full);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
